// ----- hw/rtl/lgr_pkg.sv -----
// Shared types and constants for the LDA Gibbs topic resampler.
// Holds the channel words, the controller states and the command/status bundles.
// No dependencies.
`default_nettype none
package lgr_pkg;

	localparam int NUM_TOPICS = 16;
	localparam int NUM_DOCS   = 1024;
	localparam int VOCAB_SIZE = 4096;

	localparam int TOPIC_W    = $clog2(NUM_TOPICS);
	localparam int DOC_DEPTH  = NUM_DOCS * NUM_TOPICS;
	localparam int WORD_DEPTH = VOCAB_SIZE * NUM_TOPICS;
	localparam int DOC_AW     = $clog2(DOC_DEPTH);
	localparam int WORD_AW    = $clog2(WORD_DEPTH);
	localparam int CLR_DEPTH  = (DOC_DEPTH > WORD_DEPTH) ? DOC_DEPTH : WORD_DEPTH;
	localparam int CLR_AW     = $clog2(CLR_DEPTH);

	localparam int DOC_CW   = 16;
	localparam int WORD_CW  = 20;
	localparam int TOTAL_CW = 24;
	localparam int BSUM_W   = 24;

	// (ndk<<8)+alpha, (nwk<<8)+beta, their product, (nk<<8)+beta_sum
	localparam int A_W    = DOC_CW + 9;
	localparam int B_W    = WORD_CW + 9;
	localparam int PROD_W = A_W + B_W;
	localparam int DEN_W  = TOTAL_CW + 9;
	localparam int WGT_W  = 32;
	localparam int TOT_W  = WGT_W + TOPIC_W;
	localparam int DIV_CW = $clog2(WGT_W);

	localparam logic [BSUM_W-1:0] BETA_SUM_RESET = BSUM_W'(256);

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_RESAMPLE = 2'd1;
	localparam logic [1:0] OP_ALPHA    = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [9:0]  doc_index;
		logic [11:0] word_index;
		logic [3:0]  topic;
		logic [15:0] word_beta;
		logic [15:0] alpha_value;
		logic [31:0] random_fraction;
	} item_word_t;

	typedef struct packed {
		logic [3:0] new_topic;
		logic       status;
	} result_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_DEC_RD, ST_DEC_WR,
		ST_W_RD, ST_W_MUL, ST_W_DIV0, ST_W_DIV, ST_W_ACC,
		ST_THR_MUL, ST_THR_ADD, ST_SCAN, ST_INC_RD, ST_INC_WR, ST_OUT
	} lgr_state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic alpha_wr;
		logic use_j;
		logic upd_wr;
		logic upd_up;
		logic w_mul;
		logic div_init;
		logic div_step;
		logic acc;
		logic thr_mul;
		logic thr_add;
		logic scan_step;
		logic out_load;
	} lgr_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_add;
		logic is_resample;
		logic is_alpha;
		logic in_range;
		logic topic_ok;
		logic div_last;
		logic j_last;
		logic scan_done;
		logic out_busy;
	} lgr_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lgr_ctrl.sv -----
// Controller state machine of the LDA Gibbs topic resampler.
// Depends on lgr_pkg for the state, command and status types.
`default_nettype none
module lgr_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  lgr_pkg::lgr_status_t sts,
	output lgr_pkg::lgr_cmd_t    cmd
);
	import lgr_pkg::*;

	lgr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:     if (item_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (sts.is_add && sts.in_range) state_d = ST_INC_RD;
				else if (sts.is_resample && sts.in_range) state_d = ST_DEC_RD;
				else state_d = ST_OUT;
			end
			ST_DEC_RD:   state_d = ST_DEC_WR;
			ST_DEC_WR:   state_d = ST_W_RD;
			ST_W_RD:     state_d = ST_W_MUL;
			ST_W_MUL:    state_d = ST_W_DIV0;
			ST_W_DIV0:   state_d = ST_W_DIV;
			ST_W_DIV:    if (sts.div_last) state_d = ST_W_ACC;
			ST_W_ACC:    state_d = sts.j_last ? ST_THR_MUL : ST_W_RD;
			ST_THR_MUL:  state_d = ST_THR_ADD;
			ST_THR_ADD:  state_d = ST_SCAN;
			ST_SCAN:     if (sts.scan_done) state_d = ST_INC_RD;
			ST_INC_RD:   state_d = ST_INC_WR;
			ST_INC_WR:   state_d = ST_OUT;
			ST_OUT:      if (!sts.out_busy) state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_CLEAR:    cmd.clear = 1'b1;
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ST_DISPATCH: cmd.alpha_wr = sts.is_alpha && sts.topic_ok;
			ST_DEC_WR:   cmd.upd_wr = 1'b1;
			ST_W_RD:     cmd.use_j = 1'b1;
			ST_W_MUL:    cmd.w_mul = 1'b1;
			ST_W_DIV0:   cmd.div_init = 1'b1;
			ST_W_DIV:    cmd.div_step = 1'b1;
			ST_W_ACC:    cmd.acc = 1'b1;
			ST_THR_MUL:  cmd.thr_mul = 1'b1;
			ST_THR_ADD:  cmd.thr_add = 1'b1;
			ST_SCAN:     cmd.scan_step = !sts.scan_done;
			ST_INC_WR: begin
				cmd.upd_wr = 1'b1;
				cmd.upd_up = 1'b1;
			end
			ST_OUT:      cmd.out_load = !sts.out_busy;
			default:     cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lgr_dpath.sv -----
// Datapath of the LDA Gibbs topic resampler: count memories, priors,
// weight multiplier, shared radix-2 divider, threshold and scan. Uses lgr_pkg.
`default_nettype none
module lgr_dpath (
	input  wire                      clk,
	input  wire                      arst_n,
	input  lgr_pkg::lgr_cmd_t        cmd,
	output lgr_pkg::lgr_status_t     sts,
	input  lgr_pkg::item_word_t      item,
	input  wire                      cfg_valid,
	input  wire [lgr_pkg::BSUM_W-1:0] cfg_data,
	output logic                     result_valid,
	input  wire                      result_ready,
	output lgr_pkg::result_word_t    result
);
	import lgr_pkg::*;

	logic [DOC_CW-1:0]  doc_mem  [DOC_DEPTH];
	logic [WORD_CW-1:0] word_mem [WORD_DEPTH];

	item_word_t          in_q;
	logic [BSUM_W-1:0]   beta_sum_q;
	logic [15:0]         alpha_q  [NUM_TOPICS];
	logic [TOTAL_CW-1:0] totals_q [NUM_TOPICS];
	logic [WGT_W-1:0]    weights_q[NUM_TOPICS];

	logic [DOC_CW-1:0]   doc_rd_q;
	logic [WORD_CW-1:0]  word_rd_q;
	logic [TOPIC_W-1:0]  j_q, res_topic_q;
	logic [DIV_CW-1:0]   div_cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DEN_W-1:0]    den_q, rem_q;
	logic [WGT_W-1:0]    dvd_q;
	logic                ovf_q, zero_q, sat_q;
	logic [TOT_W-1:0]    total_q, thr_q, cum_q, p_hi_q;
	logic [63:0]         p_lo_q;
	logic [CLR_AW-1:0]   clr_q;
	logic                clr_done_q;

	logic [TOPIC_W-1:0]  sel_topic, in_topic;
	logic [DOC_AW-1:0]   doc_addr;
	logic [WORD_AW-1:0]  word_addr;
	logic                doc_we, word_we;
	logic [DOC_AW-1:0]   doc_waddr;
	logic [WORD_AW-1:0]  word_waddr;
	logic [DOC_CW-1:0]   doc_new;
	logic [WORD_CW-1:0]  word_new;
	logic [TOTAL_CW-1:0] tot_cur, tot_new;
	logic                doc_sat, word_sat, tot_sat;
	logic [A_W-1:0]      a_val;
	logic [B_W-1:0]      b_val;
	logic [DEN_W-1:0]    high_part;
	logic [DEN_W:0]      trial;
	logic [WGT_W-1:0]    wgt;
	logic [TOT_W-1:0]    hi_ext, rnd_ext;
	logic [TOPIC_W-1:0]  scan_next;

	assign in_topic  = TOPIC_W'(in_q.topic);
	assign sel_topic = cmd.use_j ? j_q : res_topic_q;
	assign doc_addr  = DOC_AW'(32'(in_q.doc_index) * NUM_TOPICS + 32'(sel_topic));
	assign word_addr = WORD_AW'(32'(in_q.word_index) * NUM_TOPICS + 32'(sel_topic));

	// saturating bumps of the three counts
	assign tot_cur = totals_q[res_topic_q];
	always_comb begin
		if (cmd.upd_up) begin
			doc_sat  = (doc_rd_q == '1);
			word_sat = (word_rd_q == '1);
			tot_sat  = (tot_cur == '1);
			doc_new  = doc_sat ? doc_rd_q : doc_rd_q + 1'b1;
			word_new = word_sat ? word_rd_q : word_rd_q + 1'b1;
			tot_new  = tot_sat ? tot_cur : tot_cur + 1'b1;
		end else begin
			doc_sat  = (doc_rd_q == '0);
			word_sat = (word_rd_q == '0);
			tot_sat  = (tot_cur == '0);
			doc_new  = doc_sat ? doc_rd_q : doc_rd_q - 1'b1;
			word_new = word_sat ? word_rd_q : word_rd_q - 1'b1;
			tot_new  = tot_sat ? tot_cur : tot_cur - 1'b1;
		end
	end

	assign doc_we     = cmd.clear ? (32'(clr_q) < DOC_DEPTH) : cmd.upd_wr;
	assign word_we    = cmd.clear ? (32'(clr_q) < WORD_DEPTH) : cmd.upd_wr;
	assign doc_waddr  = cmd.clear ? DOC_AW'(clr_q) : doc_addr;
	assign word_waddr = cmd.clear ? WORD_AW'(clr_q) : word_addr;

	always_ff @(posedge clk) begin
		if (doc_we) doc_mem[doc_waddr] <= cmd.clear ? '0 : doc_new;
		doc_rd_q <= doc_mem[doc_addr];
	end

	always_ff @(posedge clk) begin
		if (word_we) word_mem[word_waddr] <= cmd.clear ? '0 : word_new;
		word_rd_q <= word_mem[word_addr];
	end

	assign a_val     = A_W'({doc_rd_q, 8'b0}) + A_W'(alpha_q[j_q]);
	assign b_val     = B_W'({word_rd_q, 8'b0}) + B_W'(in_q.word_beta);
	assign high_part = DEN_W'(prod_q[PROD_W-1:24]);
	assign trial     = {rem_q, dvd_q[WGT_W-1]};
	assign wgt       = zero_q ? '0 : (ovf_q ? '1 : dvd_q);
	assign hi_ext    = TOT_W'(total_q[TOT_W-1:WGT_W]);
	assign rnd_ext   = TOT_W'(in_q.random_fraction);
	assign scan_next = res_topic_q + 1'b1;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= item;
		if (cmd.w_mul) begin
			prod_q <= PROD_W'(a_val) * PROD_W'(b_val);
			den_q  <= DEN_W'({totals_q[j_q], 8'b0}) + DEN_W'(beta_sum_q);
		end
		if (cmd.div_init) begin
			rem_q  <= high_part;
			dvd_q  <= {prod_q[23:0], 8'b0};
			zero_q <= (den_q == '0) && (prod_q == '0);
			ovf_q  <= (den_q == '0) ? (prod_q != '0) : (high_part >= den_q);
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				dvd_q <= {dvd_q[WGT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				dvd_q <= {dvd_q[WGT_W-2:0], 1'b0};
			end
		end
		if (cmd.acc) weights_q[j_q] <= wgt;
		if (cmd.thr_mul) begin
			p_lo_q <= 64'(total_q[WGT_W-1:0]) * 64'(in_q.random_fraction);
			p_hi_q <= hi_ext * rnd_ext;
		end
		if (cmd.thr_add) begin
			thr_q <= p_hi_q + TOT_W'(p_lo_q[63:32]);
			cum_q <= TOT_W'(weights_q[0]);
		end else if (cmd.scan_step) begin
			cum_q <= cum_q + TOT_W'(weights_q[scan_next]);
		end
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_sum_q   <= BETA_SUM_RESET;
			alpha_q      <= '{default: '0};
			totals_q     <= '{default: '0};
			j_q          <= '0;
			res_topic_q  <= '0;
			div_cnt_q    <= '0;
			total_q      <= '0;
			sat_q        <= 1'b0;
			clr_q        <= '0;
			clr_done_q   <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (cfg_valid) beta_sum_q <= cfg_data;
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
				if (32'(clr_q) == CLR_DEPTH - 1) clr_done_q <= 1'b1;
			end
			if (cmd.capture) begin
				j_q         <= '0;
				total_q     <= '0;
				sat_q       <= 1'b0;
				res_topic_q <= TOPIC_W'(item.topic);
			end
			if (cmd.alpha_wr) alpha_q[in_topic] <= in_q.alpha_value;
			if (cmd.upd_wr) begin
				totals_q[res_topic_q] <= tot_new;
				sat_q <= sat_q | doc_sat | word_sat | tot_sat;
			end
			if (cmd.div_init) div_cnt_q <= '0;
			else if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.acc) begin
				total_q <= total_q + TOT_W'(wgt);
				j_q     <= j_q + 1'b1;
			end
			if (cmd.thr_add) res_topic_q <= '0;
			else if (cmd.scan_step) res_topic_q <= scan_next;
			if (cmd.out_load) begin
				result_valid     <= 1'b1;
				result.status    <= sat_q;
				result.new_topic <= (sts.is_resample && sts.in_range) ?
					4'(res_topic_q) : in_q.topic;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clear_done  = clr_done_q;
		sts.is_add      = (in_q.opcode == OP_ADD);
		sts.is_resample = (in_q.opcode == OP_RESAMPLE);
		sts.is_alpha    = (in_q.opcode == OP_ALPHA);
		sts.topic_ok    = 32'(in_q.topic) < NUM_TOPICS;
		sts.in_range    = sts.topic_ok && (32'(in_q.doc_index) < NUM_DOCS)
			&& (32'(in_q.word_index) < VOCAB_SIZE);
		sts.div_last    = (div_cnt_q == DIV_CW'(WGT_W - 1));
		sts.j_last      = (j_q == TOPIC_W'(NUM_TOPICS - 1));
		sts.scan_done   = !(cum_q < thr_q) || (res_topic_q == TOPIC_W'(NUM_TOPICS - 1));
		sts.out_busy    = result_valid && !result_ready;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lda_gibbs_topic_resampler.sv -----
// Top level of the LDA collapsed Gibbs topic resampler.
// Instantiates lgr_ctrl and lgr_dpath; types come from lgr_pkg.
`default_nettype none
// The block keeps the LDA count tables (document x topic, word x topic,
// per-topic totals) and one Q8.8 alpha per topic, and takes one token word
// at a time. After reset it first zeroes the count memories, one entry per
// cycle across the 65536 entries of the word x topic memory, and accepts no
// item word until that pass is over; the beta_sum register may be written at
// any time. An add-token word passes dispatch, a count read, a count write and
// the output state; a load-alpha word or a word with the unused opcode goes
// from dispatch straight to the output state. A resample first decrements the
// old topic's counts; then each topic's weight goes through one read of the
// count memories, one multiply, and a shared divider that retires one quotient
// bit per cycle; a threshold and a scan then pick the new topic. One word is in
// the block at a time; the finished result sits in an output register, so the
// next item word is taken while that result waits for result_ready.
module lda_gibbs_topic_resampler (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	output logic                      item_ready,
	input  lgr_pkg::item_word_t       item,
	output logic                      result_valid,
	input  wire                       result_ready,
	output lgr_pkg::result_word_t     result,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire [lgr_pkg::BSUM_W-1:0] cfg_data
);
	import lgr_pkg::*;

	lgr_cmd_t    cmd;
	lgr_status_t sts;

	// the register takes a write word in any cycle
	assign cfg_ready = 1'b1;

	lgr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lgr_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for lda_gibbs_topic_resampler.
// Drives token words through the valid/ready channels, predicts each result
// from its own copy of the count tables; depends on lgr_pkg and the block RTL.
`default_nettype none
module tb_top;
	import lgr_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYCLES = 800;   // a bit more than one resample

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_word_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_word_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [BSUM_W-1:0] cfg_data = '0;

	lda_gibbs_topic_resampler DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted state of the block's count tables and register.
	bit [15:0] doc_counts [DOC_DEPTH];
	bit [19:0] word_counts [WORD_DEPTH];
	bit [23:0] topic_totals [NUM_TOPICS];
	bit [15:0] alpha_by_topic [NUM_TOPICS];
	bit [23:0] beta_sum_model = BETA_SUM_RESET;

	result_word_t expected_results [$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_left = 0;
	int unsigned cycle_count = 0;

	// Step a count up or down; flag when it sticks at a limit.
	function automatic bit bump_count(inout bit [31:0] cnt, input bit [31:0] maxv,
			input bit up);
		if (up) begin
			if (cnt >= maxv) begin
				cnt = maxv;
				return 1'b1;
			end
			cnt++;
		end else begin
			if (cnt == 0) return 1'b1;
			cnt--;
		end
		return 1'b0;
	endfunction

	function automatic bit move_token(bit [9:0] d, bit [11:0] w, bit [3:0] k, bit up);
		bit sat;
		bit [31:0] v;
		sat = 1'b0;
		v = doc_counts[{d, k}];
		sat |= bump_count(v, 32'hFFFF, up);
		doc_counts[{d, k}] = v[15:0];
		v = word_counts[{w, k}];
		sat |= bump_count(v, 32'hFFFFF, up);
		word_counts[{w, k}] = v[19:0];
		v = topic_totals[k];
		sat |= bump_count(v, 32'hFFFFFF, up);
		topic_totals[k] = v[23:0];
		return sat;
	endfunction

	// Draw a topic from the collapsed Gibbs conditional, fixed point.
	function automatic bit [3:0] draw_topic(bit [9:0] d, bit [11:0] w, bit [15:0] beta,
			bit [31:0] rnd);
		bit [63:0] wgt [NUM_TOPICS];
		bit [63:0] a, b, num, den, q, total, thr, cum;
		int t;
		total = 0;
		for (int k = 0; k < NUM_TOPICS; k++) begin
			a = ({48'd0, doc_counts[{d, 4'(k)}]} << 8) + alpha_by_topic[k];
			b = ({44'd0, word_counts[{w, 4'(k)}]} << 8) + beta;
			den = ({40'd0, topic_totals[k]} << 8) + beta_sum_model;
			num = (a * b) << 8;
			if (den == 0) q = (num == 0) ? 64'd0 : 64'hFFFF_FFFF;
			else begin
				q = num / den;
				if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
			end
			wgt[k] = q;
			total += q;
		end
		thr = (total >> 32) * rnd + (((total & 64'hFFFF_FFFF) * rnd) >> 32);
		cum = wgt[0];
		t = 0;
		while (cum < thr && t < NUM_TOPICS - 1) begin
			t++;
			cum += wgt[t];
		end
		return 4'(t);
	endfunction

	function automatic result_word_t apply_token_op(item_word_t it);
		result_word_t r;
		r.new_topic = it.topic;
		r.status = 1'b0;
		case (it.opcode)
			OP_ADD: r.status = move_token(it.doc_index, it.word_index, it.topic, 1'b1);
			OP_RESAMPLE: begin
				r.status = move_token(it.doc_index, it.word_index, it.topic, 1'b0);
				r.new_topic = draw_topic(it.doc_index, it.word_index, it.word_beta,
					it.random_fraction);
				r.status |= move_token(it.doc_index, it.word_index, r.new_topic, 1'b1);
			end
			OP_ALPHA: alpha_by_topic[it.topic] = it.alpha_value;
			default: ;
		endcase
		return r;
	endfunction

	// Offer one word, hold it until accepted, then predict its result.
	task automatic send_item(item_word_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat ($urandom_range(12)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		expected_results.push_back(apply_token_op(it));
	endtask

	task automatic release_item();
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic wait_drained();
		release_item();
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Write beta_sum while the block is idle.
	task automatic write_beta_sum(bit [23:0] value);
		wait_drained();
		@(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		beta_sum_model = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic item_word_t make_item(bit [1:0] op, bit [9:0] d, bit [11:0] w,
			bit [3:0] k, bit [15:0] beta, bit [15:0] alpha, bit [31:0] rnd);
		item_word_t it;
		it.opcode = op;
		it.doc_index = d;
		it.word_index = w;
		it.topic = k;
		it.word_beta = beta;
		it.alpha_value = alpha;
		it.random_fraction = rnd;
		return it;
	endfunction

	// Mostly a small corpus so counts build up; some words are fully random.
	function automatic item_word_t random_item();
		item_word_t it;
		int pick;
		it = item_word_t'({$urandom, $urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 85) begin
			it.doc_index = 10'($urandom_range(7));
			it.word_index = 12'($urandom_range(15));
			if ($urandom_range(3) != 0) it.word_beta = 16'($urandom_range(1023));
			if (pick < 40) it.opcode = OP_ADD;
			else if (pick < 78) it.opcode = OP_RESAMPLE;
			else if (pick < 83) it.opcode = OP_ALPHA;
			else it.opcode = OP_UNUSED;
		end else if (pick < 95) begin
			it.opcode = ($urandom_range(1) != 0) ? OP_RESAMPLE : OP_ADD;
		end
		return it;
	endfunction

	task automatic test_directed();
		send_item(make_item(OP_RESAMPLE, 0, 0, 0, 0, 0, 0));       // decrement at zero
		send_item(make_item(OP_ADD, 0, 0, 0, 16'h0100, 0, 0));
		send_item(make_item(OP_ADD, 10'h3FF, 12'hFFF, 4'hF, 16'hFFFF, 16'hFFFF, '1));
		send_item(make_item(OP_ALPHA, 0, 0, 4'h0, 0, 16'h0000, 0));
		send_item(make_item(OP_ALPHA, 0, 0, 4'hF, 0, 16'hFFFF, 0));
		send_item(make_item(OP_ALPHA, 0, 0, 4'h3, 0, 16'h0180, 0));
		send_item(make_item(OP_RESAMPLE, 0, 0, 0, 16'h0100, 0, 32'h0));
		send_item(make_item(OP_RESAMPLE, 0, 0, 0, 16'h0100, 0, 32'hFFFF_FFFF));
		send_item(make_item(OP_RESAMPLE, 10'h3FF, 12'hFFF, 4'hF, 16'hFFFF, 0, 32'h8000_0000));
		send_item(make_item(OP_RESAMPLE, 10'h3FF, 12'hFFF, 4'h7, 16'h0000, 0, 32'h4000_0000));
		send_item(make_item(OP_UNUSED, 10'h155, 12'hAAA, 4'h9, 16'h1234, 16'h5678, '1));
		// zero denominator on untouched topics
		write_beta_sum(24'h0);
		send_item(make_item(OP_RESAMPLE, 5, 5, 2, 16'h0000, 0, 32'h1234_5678));
		send_item(make_item(OP_RESAMPLE, 5, 5, 2, 16'h0040, 0, 32'hC000_0000));
		write_beta_sum(24'hFFFFFF);
		send_item(make_item(OP_ADD, 5, 5, 4, 16'hFFFF, 0, 0));
		send_item(make_item(OP_RESAMPLE, 5, 5, 4, 16'hFFFF, 0, 32'h7FFF_FFFF));
		wait_drained();
	endtask

	task automatic test_random_phase(int idle_pct, int stall_pct, int count,
			bit [23:0] beta_sum_value);
		write_beta_sum(beta_sum_value);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_item(random_item());
	endtask

	// Hold the receiver off so the block backs up, then drain and send more words.
	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = 3000;
		repeat (12) send_item(random_item());
		wait_drained();
		repeat (20) send_item(random_item());
	endtask

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			hold_off_left--;
			result_ready = 1'b0;
		end else begin
			result_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: new_topic=%0d status=%0d",
					result.new_topic, result.status);
				error_count++;
			end else begin
				result_word_t exp_r;
				exp_r = expected_results.pop_front();
				if (result.new_topic !== exp_r.new_topic) begin
					$error("new_topic: expected %0d, got %0d", exp_r.new_topic,
						result.new_topic);
					error_count++;
				end
				if (result.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, result.status);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lda_gibbs_topic_resampler test failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_phase(0, 0, 400, 24'h000100);
		test_random_phase(61, 0, 400, 24'($urandom));
		test_back_pressure();
		test_random_phase(0, 61, 400, 24'h000000);
		test_random_phase(12, 12, 400, 24'($urandom_range(4095)));
		test_random_phase(0, 0, 60, 24'hFFFFFF);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("lda_gibbs_topic_resampler test passed");
		end else begin
			$display("lda_gibbs_topic_resampler test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/lgr_pkg.sv
hw/rtl/lgr_ctrl.sv
hw/rtl/lgr_dpath.sv
hw/rtl/lda_gibbs_topic_resampler.sv
dv/tb_top.sv
